// ===== rtl/scba_pkg.sv =====
// Shared widths, codes and controller/datapath interface types of the size-class allocator.
`default_nettype none

package scba_pkg;

   // fixed field widths
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned REQ_W     = 32;
   localparam int unsigned HANDLE_W  = 10;
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned BYTES_W   = 32;
   localparam int unsigned STATUS_W  = 3;

   // parameter defaults
   localparam int unsigned MIN_SHIFT_DEF    = 6;
   localparam int unsigned NUM_CLASSES_DEF  = 16;
   localparam int unsigned MAX_BLOCKS_DEF   = 1024;
   localparam int unsigned HEADER_BYTES_DEF = 32;

   // request modes
   localparam logic [MODE_W-1:0] MODE_CHECKOUT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RESERVE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMIT    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_EXCHANGE = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_POOL_EMPTY = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_TOO_LARGE  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_UNDERFLOW  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW   = 3'd4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request fields, classify size
      logic fetch;    // issue table reads
      logic exec;     // main update and result
      logic extra;    // second count write of an exchange
      logic publish;  // move result into the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic two_writes;  // exchange of two distinct in-range handles
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/scba_ctrl.sv =====
// Sequencing state machine and response-valid register of the size-class allocator.
`default_nettype none

module scba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  scba_pkg::sts_type sts,
   output scba_pkg::cmd_type cmd
);
   import scba_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_EXTRA = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.two_writes ? ST_EXTRA : ST_REPLY;
         end
         ST_EXTRA: begin
            cmd.extra = 1'b1;
            state_in  = ST_REPLY;
         end
         ST_REPLY: begin
            if (slot_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/scba_datapath.sv =====
// Tables, free lists, counters and response register of the size-class allocator.
`default_nettype none

module scba_datapath #(
   parameter int unsigned MIN_SHIFT    = scba_pkg::MIN_SHIFT_DEF,
   parameter int unsigned NUM_CLASSES  = scba_pkg::NUM_CLASSES_DEF,
   parameter int unsigned MAX_BLOCKS   = scba_pkg::MAX_BLOCKS_DEF,
   parameter int unsigned HEADER_BYTES = scba_pkg::HEADER_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [scba_pkg::MODE_W-1:0]      req_mode,
   input  logic [scba_pkg::REQ_W-1:0]       req_request_bytes,
   input  logic [scba_pkg::HANDLE_W-1:0]    req_first_handle,
   input  logic [scba_pkg::HANDLE_W-1:0]    req_second_handle,
   input  scba_pkg::cmd_type                cmd,
   output scba_pkg::sts_type                sts,
   output logic [scba_pkg::HANDLE_W-1:0]    rsp_block_handle,
   output logic [scba_pkg::COUNT_W-1:0]     rsp_remaining_count,
   output logic [scba_pkg::BYTES_W-1:0]     rsp_total_bytes,
   output logic [scba_pkg::STATUS_W-1:0]    rsp_status
);
   import scba_pkg::*;

   localparam int unsigned AW    = $clog2(MAX_BLOCKS);
   localparam int unsigned CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int unsigned FW    = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned NEEDW = REQ_W + 1;

   typedef struct packed {
      logic          valid;
      logic [AW-1:0] handle;
   } link_type;

   // captured request
   logic [MODE_W-1:0]   mode_ff;
   logic [HANDLE_W-1:0] h1_ff, h2_ff;
   logic [CW-1:0]       cls_ff, cls_in;
   logic                big_ff, big_in;
   logic                ok1_ff, ok2_ff;

   // allocator state
   logic                head_valid_ff [NUM_CLASSES];
   logic                head_valid_in [NUM_CLASSES];
   logic [AW-1:0]       free_head_ff  [NUM_CLASSES];
   logic [AW-1:0]       free_head_in  [NUM_CLASSES];
   logic [FW-1:0]       fresh_ff, fresh_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;

   // tables
   link_type            link_mem  [MAX_BLOCKS];
   logic [COUNT_W-1:0]  count_mem [MAX_BLOCKS];
   logic [CW-1:0]       class_mem [MAX_BLOCKS];

   link_type            link_rd_ff;
   logic [COUNT_W-1:0]  cnt1_rd_ff, cnt2_rd_ff;
   logic [CW-1:0]       bcls_rd_ff;

   // table write ports
   logic                cnt_we, link_we, class_we;
   logic [AW-1:0]       cnt_wa, link_wa, class_wa;
   logic [COUNT_W-1:0]  cnt_wd;
   link_type            link_wd;
   logic [CW-1:0]       class_wd;

   // result
   logic [HANDLE_W-1:0] handle_res_ff, handle_res_in;
   logic [COUNT_W-1:0]  count_res_ff, count_res_in;
   logic [STATUS_W-1:0] status_res_ff, status_res_in;

   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [BYTES_W-1:0]  rsp_bytes_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // misc combinational
   logic [NEEDW-1:0]       need;
   logic [NUM_CLASSES-1:0] over;
   logic [AW-1:0]          idx1, idx2, pop_h, fresh_h;
   logic                   bcls_ok;
   logic [CW-1:0]          bcls_sel;
   logic                   do_drop, is_xchg;
   logic [COUNT_W-1:0]     left;
   logic [63:0]            blk_size, bytes_sum;

   assign idx1     = AW'(h1_ff);
   assign idx2     = AW'(h2_ff);
   assign pop_h    = free_head_ff[cls_ff];
   assign fresh_h  = AW'(fresh_ff);
   assign bcls_ok  = (32'(bcls_rd_ff) < NUM_CLASSES);
   assign bcls_sel = bcls_ok ? bcls_rd_ff : '0;
   assign left     = cnt1_rd_ff - COUNT_W'(1);
   assign blk_size  = 64'(1) << (MIN_SHIFT + 32'(cls_ff));
   assign bytes_sum = 64'(bytes_ff) + blk_size;

   assign sts.two_writes = (mode_ff == MODE_EXCHANGE) && ok1_ff && ok2_ff && (h1_ff != h2_ff);

   // size class: thermometer of "need exceeds 2^(MIN_SHIFT+i)"
   always_comb begin
      need = NEEDW'(req_request_bytes) + NEEDW'(HEADER_BYTES);
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if (MIN_SHIFT + i < NEEDW) begin
            over[i] = (need > (NEEDW'(1) << (MIN_SHIFT + i)));
         end else begin
            over[i] = 1'b0;
         end
      end
      big_in = over[NUM_CLASSES-1];
      cls_in = '0;
      for (int i = 1; i < NUM_CLASSES; i++) begin
         if (over[i-1] && !over[i]) begin
            cls_in = cls_in | CW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         h1_ff   <= req_first_handle;
         h2_ff   <= req_second_handle;
         cls_ff  <= cls_in;
         big_ff  <= big_in;
         ok1_ff  <= (32'(req_first_handle) < MAX_BLOCKS);
         ok2_ff  <= (32'(req_second_handle) < MAX_BLOCKS);
      end
   end

   // main update
   always_comb begin
      head_valid_in = head_valid_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      bytes_in      = bytes_ff;
      cnt_we        = 1'b0;
      cnt_wa        = idx1;
      cnt_wd        = left;
      link_we       = 1'b0;
      link_wa       = idx1;
      link_wd       = '{valid: head_valid_ff[bcls_sel], handle: free_head_ff[bcls_sel]};
      class_we      = 1'b0;
      class_wa      = fresh_h;
      class_wd      = cls_ff;
      handle_res_in = '0;
      count_res_in  = '0;
      status_res_in = STAT_OK;
      do_drop       = 1'b0;
      is_xchg       = 1'b0;

      if (cmd.exec) begin
         case (mode_ff)
            MODE_CHECKOUT: begin
               if (big_ff) begin
                  status_res_in = STAT_TOO_LARGE;
               end else if (head_valid_ff[cls_ff]) begin
                  head_valid_in[cls_ff] = link_rd_ff.valid;
                  free_head_in[cls_ff]  = link_rd_ff.handle;
                  // popped block is off the list: its link no longer counts
                  link_we       = 1'b1;
                  link_wa       = pop_h;
                  link_wd       = '{valid: 1'b0, handle: link_rd_ff.handle};
                  cnt_we        = 1'b1;
                  cnt_wa        = pop_h;
                  cnt_wd        = COUNT_W'(1);
                  handle_res_in = HANDLE_W'(pop_h);
                  count_res_in  = COUNT_W'(1);
               end else if (fresh_ff == FW'(MAX_BLOCKS)) begin
                  status_res_in = STAT_POOL_EMPTY;
               end else begin
                  fresh_in      = fresh_ff + FW'(1);
                  bytes_in      = (bytes_sum > 64'(BYTES_MAX)) ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
                  class_we      = 1'b1;
                  cnt_we        = 1'b1;
                  cnt_wa        = fresh_h;
                  cnt_wd        = COUNT_W'(1);
                  handle_res_in = HANDLE_W'(fresh_ff);
                  count_res_in  = COUNT_W'(1);
               end
            end
            MODE_RESERVE: begin
               if (ok1_ff) begin
                  if (cnt1_rd_ff == COUNT_MAX) begin
                     status_res_in = STAT_OVERFLOW;
                     count_res_in  = COUNT_MAX;
                  end else begin
                     cnt_we       = 1'b1;
                     cnt_wd       = cnt1_rd_ff + COUNT_W'(1);
                     count_res_in = cnt1_rd_ff + COUNT_W'(1);
                  end
               end
            end
            MODE_REMIT: begin
               do_drop = ok1_ff;
            end
            MODE_EXCHANGE: begin
               if (ok1_ff && ok2_ff) begin
                  if (h1_ff == h2_ff) begin
                     count_res_in = cnt1_rd_ff;
                  end else begin
                     do_drop = 1'b1;
                     is_xchg = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase

         if (do_drop) begin
            if (cnt1_rd_ff == '0) begin
               status_res_in = STAT_UNDERFLOW;
            end else begin
               cnt_we       = 1'b1;
               count_res_in = left;
               if (is_xchg && (cnt2_rd_ff == COUNT_MAX)) begin
                  status_res_in = STAT_OVERFLOW;
               end
               // count reached zero: push onto its class list
               if ((left == '0) && bcls_ok) begin
                  link_we                 = 1'b1;
                  head_valid_in[bcls_sel] = 1'b1;
                  free_head_in[bcls_sel]  = idx1;
               end
            end
         end
      end

      // second half of an exchange: raise the other handle
      if (cmd.extra && (cnt2_rd_ff != COUNT_MAX)) begin
         cnt_we = 1'b1;
         cnt_wa = idx2;
         cnt_wd = cnt2_rd_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_valid_ff[i] <= 1'b0;
         end
         fresh_ff <= '0;
         bytes_ff <= '0;
      end else begin
         head_valid_ff <= head_valid_in;
         fresh_ff      <= fresh_in;
         bytes_ff      <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      free_head_ff <= free_head_in;
      if (cmd.exec) begin
         handle_res_ff <= handle_res_in;
         count_res_ff  <= count_res_in;
         status_res_ff <= status_res_in;
      end
   end

   // count table: one write, two reads
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_wa] <= cnt_wd;
      end
      if (cmd.fetch) begin
         cnt1_rd_ff <= count_mem[idx1];
         cnt2_rd_ff <= count_mem[idx2];
      end
   end

   // link table
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (cmd.fetch) begin
         link_rd_ff <= link_mem[pop_h];
      end
   end

   // class table
   always_ff @(posedge clock) begin
      if (class_we) begin
         class_mem[class_wa] <= class_wd;
      end
      if (cmd.fetch) begin
         bcls_rd_ff <= class_mem[idx1];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_handle_ff <= handle_res_ff;
         rsp_count_ff  <= count_res_ff;
         rsp_bytes_ff  <= bytes_ff;
         rsp_status_ff <= status_res_ff;
      end
   end

   assign rsp_block_handle    = rsp_handle_ff;
   assign rsp_remaining_count = rsp_count_ff;
   assign rsp_total_bytes     = rsp_bytes_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

`default_nettype wire

// ===== rtl/size_class_block_allocator_top.sv =====
// Top level of the reference-counted size-class block allocator.
//
// Requests arrive on req_* (valid/ready): mode 0 checks out a block of
// req_request_bytes payload, mode 1 reserves, mode 2 remits req_first_handle,
// mode 3 remits req_first_handle and reserves req_second_handle.
// Every request yields exactly one response on rsp_* (valid/ready).
// After the accept, the sequencer steps through fetch, exec and reply, and
// rsp_valid is registered in the reply step; an exchange of two distinct
// handles adds an extra step for the second write to the single-write-port count table.
// req_ready is high only while the sequencer is idle, so a new request is not
// taken before the last one is published, as each request reads and then
// writes the count, link and class tables.
// The response sits in an output register; a stalled receiver holds it
// while the next request is accepted and worked, and that request waits
// only at its final step until the register frees.
// Reset (synchronous, active high) empties every free list, rewinds the
// fresh-block pool and zeroes the byte total. Count, link and class tables
// are not cleared: an entry is only meaningful once a check out wrote it.
`default_nettype none

module size_class_block_allocator_top #(
   parameter int unsigned MIN_SHIFT    = scba_pkg::MIN_SHIFT_DEF,
   parameter int unsigned NUM_CLASSES  = scba_pkg::NUM_CLASSES_DEF,
   parameter int unsigned MAX_BLOCKS   = scba_pkg::MAX_BLOCKS_DEF,
   parameter int unsigned HEADER_BYTES = scba_pkg::HEADER_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [scba_pkg::MODE_W-1:0]   req_mode,
   input  logic [scba_pkg::REQ_W-1:0]    req_request_bytes,
   input  logic [scba_pkg::HANDLE_W-1:0] req_first_handle,
   input  logic [scba_pkg::HANDLE_W-1:0] req_second_handle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [scba_pkg::HANDLE_W-1:0] rsp_block_handle,
   output logic [scba_pkg::COUNT_W-1:0]  rsp_remaining_count,
   output logic [scba_pkg::BYTES_W-1:0]  rsp_total_bytes,
   output logic [scba_pkg::STATUS_W-1:0] rsp_status
);
   import scba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: idle, fetch, exec, optional extra write, reply
   scba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, free-list heads, pool counter, byte total, response payload
   scba_datapath #(
      .MIN_SHIFT    (MIN_SHIFT),
      .NUM_CLASSES  (NUM_CLASSES),
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_mode),
      .req_request_bytes   (req_request_bytes),
      .req_first_handle    (req_first_handle),
      .req_second_handle   (req_second_handle),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_block_handle    (rsp_block_handle),
      .rsp_remaining_count (rsp_remaining_count),
      .rsp_total_bytes     (rsp_total_bytes),
      .rsp_status          (rsp_status)
   );

`ifndef SYNTHESIS
   // one request in flight: ready drops straight after an accept
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another in flight");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_POOL_EMPTY ||
                     rsp_status == STAT_TOO_LARGE || rsp_status == STAT_UNDERFLOW ||
                     rsp_status == STAT_OVERFLOW))
      else $error("undefined status code");

   // a non-zero handle only comes from a successful check out
   a_handle_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_handle != '0) |->
         (rsp_status == STAT_OK && rsp_remaining_count == COUNT_W'(1)))
      else $error("handle given with failed check out");

   // pool exhaustion hands out no reservation
   a_pool_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_POOL_EMPTY) |->
         (rsp_remaining_count == '0 && rsp_block_handle == '0))
      else $error("pool empty response carries a block");
`endif

endmodule

`default_nettype wire
